### design/pan_tilt_status_frame_parser_assert.svh
// Assertion macros for the checker file of the status frame parser.
// No dependencies; expects signals clk and rst in the scope of use.
`ifndef PAN_TILT_STATUS_FRAME_PARSER_ASSERT_SVH
`define PAN_TILT_STATUS_FRAME_PARSER_ASSERT_SVH

// Clocked assertion, disabled while reset is high.
`define PTSFP_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Clocked assertion that also holds across reset.
`define PTSFP_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

### design/ptsfp_pkg.sv
// Package for the pan-tilt status frame parser: frame layout constants
// and the header byte lookup. No dependencies.
package ptsfp_pkg;

  localparam logic [31:0] HEADER_WORD = 32'h535A_4859;
  localparam logic [7:0]  YAW_COMMAND = 8'h10;

  // Frame byte offsets
  localparam logic [3:0] POS_HUNT    = 4'd0;
  localparam logic [3:0] POS_BODY    = 4'd4;
  localparam logic [3:0] POS_COMMAND = 4'd5;
  localparam logic [3:0] POS_A_HIGH  = 4'd6;
  localparam logic [3:0] POS_A_LOW   = 4'd7;
  localparam logic [3:0] POS_B_HIGH  = 4'd8;
  localparam logic [3:0] POS_B_LOW   = 4'd9;
  localparam logic [3:0] POS_CHECK   = 4'd10;

  // Scan modes that allow a yaw update
  localparam logic [1:0] MODE_SWEEP = 2'd0;
  localparam logic [1:0] MODE_FAN   = 2'd1;

  function automatic logic [7:0] header_byte(input logic [1:0] idx);
    header_byte = HEADER_WORD[8*idx +: 8];
  endfunction

endpackage

### design/pan_tilt_status_frame_parser.sv
// Pan-tilt status frame parser top level: byte-wise header hunt, field
// capture and checksum test. Depends on ptsfp_pkg.
// Usage:
//   Input channel (in_valid/in_ready, rx_byte): one received serial byte per
//   request. Hunt for the header 59 48 5A 53, then collect length, command,
//   two big-endian words and a checksum byte.
//   Output channel (out_valid/out_ready): one request per good frame with
//   command_code, word_a, word_b and yaw_update. Drop bad frames silently.
//   Config channel (cfg_valid/cfg_ready, pan_mode): write the scan mode;
//   cfg_ready is always high. Write it only while the parser is idle.
// Timing:
//   Take one byte per cycle, back to back, bar a stalled checksum byte. Show
//   a frame's result, registered, in the cycle after its checksum is taken.
// Reset (rst, synchronous, active high):
//   Return to the header hunt, clear the sum, set scan mode to sweep and
//   drop any pending result.
// Receiver stall:
//   Hold the result while out_ready is low. Bytes keep flowing until a
//   checksum byte arrives with the result register still full; only that
//   byte waits, since it is the one that can fill the register again.
module pan_tilt_status_frame_parser (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  rx_byte,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  pan_mode,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  command_code,
  output logic [15:0] word_a,
  output logic [15:0] word_b,
  output logic        yaw_update
);
  import ptsfp_pkg::*;

  // Parser state
  logic [3:0]  byte_position, byte_position_next;
  logic [7:0]  running_sum, running_sum_next;
  logic [7:0]  held_command, held_command_next;
  logic [15:0] held_word_a, held_word_a_next;
  logic [15:0] held_word_b, held_word_b_next;
  logic [1:0]  pan_mode_reg;

  logic [3:0] pos_eff;
  logic       in_fire;
  logic       frame_good;

  assign cfg_ready = 1'b1;

  // A position beyond the checksum cannot arise; treat it as hunting.
  assign pos_eff = (byte_position > POS_CHECK) ? POS_HUNT : byte_position;

  // Stall only the checksum byte while the result register is still full.
  assign in_ready = !(out_valid && !out_ready && (pos_eff == POS_CHECK));
  assign in_fire  = in_valid && in_ready;

  always_comb begin
    byte_position_next = byte_position;
    running_sum_next   = running_sum;
    held_command_next  = held_command;
    held_word_a_next   = held_word_a;
    held_word_b_next   = held_word_b;
    frame_good         = 1'b0;
    if (in_fire) begin
      if (pos_eff < POS_BODY) begin
        // Header hunt; a mismatching 0x59 restarts as a first header byte.
        if (rx_byte == header_byte(pos_eff[1:0])) begin
          running_sum_next   = ((pos_eff == POS_HUNT) ? 8'd0 : running_sum) + rx_byte;
          byte_position_next = pos_eff + 4'd1;
        end else if (rx_byte == header_byte(2'd0)) begin
          running_sum_next   = rx_byte;
          byte_position_next = 4'd1;
        end else begin
          running_sum_next   = 8'd0;
          byte_position_next = POS_HUNT;
        end
      end else if (pos_eff < POS_CHECK) begin
        // Body bytes: capture fields, advance the sum.
        case (pos_eff)
          POS_COMMAND: held_command_next = rx_byte;
          POS_A_HIGH:  held_word_a_next  = {rx_byte, held_word_a[7:0]};
          POS_A_LOW:   held_word_a_next  = {held_word_a[15:8], rx_byte};
          POS_B_HIGH:  held_word_b_next  = {rx_byte, held_word_b[7:0]};
          POS_B_LOW:   held_word_b_next  = {held_word_b[15:8], rx_byte};
          default:     ;
        endcase
        running_sum_next   = running_sum + rx_byte;
        byte_position_next = pos_eff + 4'd1;
      end else begin
        // Checksum byte: emit on match, restart the hunt either way.
        frame_good         = (rx_byte == running_sum);
        running_sum_next   = 8'd0;
        byte_position_next = POS_HUNT;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position <= POS_HUNT;
      running_sum   <= 8'd0;
      held_command  <= 8'd0;
      held_word_a   <= 16'd0;
      held_word_b   <= 16'd0;
      pan_mode_reg  <= MODE_SWEEP;
    end else begin
      byte_position <= byte_position_next;
      running_sum   <= running_sum_next;
      held_command  <= held_command_next;
      held_word_a   <= held_word_a_next;
      held_word_b   <= held_word_b_next;
      if (cfg_valid && cfg_ready) begin
        pan_mode_reg <= pan_mode;
      end
    end
  end

  // Result register: load on a good frame, drop valid once taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (frame_good) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (frame_good) begin
      command_code <= held_command;
      word_a       <= held_word_a;
      word_b       <= held_word_b;
      yaw_update   <= (held_command == YAW_COMMAND) &&
                      ((pan_mode_reg == MODE_SWEEP) || (pan_mode_reg == MODE_FAN));
    end
  end

endmodule

### design/ptsfp_checker.sv
// Port-level checker for the pan-tilt status frame parser, with its bind.
// Depends on ptsfp_pkg and pan_tilt_status_frame_parser_assert.svh.
`include "pan_tilt_status_frame_parser_assert.svh"

module ptsfp_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [7:0]  command_code,
  input logic [15:0] word_a,
  input logic [15:0] word_b,
  input logic        yaw_update
);
  import ptsfp_pkg::*;

  logic        stalled;
  logic        in_fire;
  logic        yaw_shown;
  logic [40:0] out_payload;

  assign stalled     = out_valid && !out_ready;
  assign in_fire     = in_valid && in_ready;
  assign yaw_shown   = out_valid && yaw_update;
  assign out_payload = {command_code, word_a, word_b, yaw_update};

  // Hold a stalled result unchanged.
  `PTSFP_ASSERT(a_out_hold, stalled |=> out_valid && $stable(out_payload), "held result changed")

  // Clear any result at reset.
  `PTSFP_ASSERT_ALWAYS(a_reset_clear, rst |=> !out_valid, "result valid after reset")

  // A new result follows an accepted byte.
  `PTSFP_ASSERT(a_result_cause, $rose(out_valid) |-> $past(in_fire), "result without a byte")

  // Yaw updates only come with the yaw command.
  `PTSFP_ASSERT(a_yaw_cmd, yaw_shown |-> command_code == YAW_COMMAND, "yaw on other command")

endmodule

bind pan_tilt_status_frame_parser ptsfp_checker u_ptsfp_checker (.*);
